FILE: src/sic_pkg.sv
// Shared types and constants for the sequence integrity checker.
package sic_pkg;

  // Default width of the per-run row position counter
  localparam int unsigned ROW_INDEX_BITS_DEF = 32;

  // Verdict codes carried on the result channel
  typedef enum logic [2:0] {
    VERDICT_OK            = 3'd0,
    VERDICT_CAP_NONINC    = 3'd1,
    VERDICT_ING_NONINC    = 3'd2,
    VERDICT_CAP_PARTIAL   = 3'd3,
    VERDICT_ING_PARTIAL   = 3'd4,
    VERDICT_CAP_ABSENT    = 3'd5,
    VERDICT_ING_ABSENT    = 3'd6
  } verdict_t;

  // Channel health codes
  typedef enum logic [1:0] {
    HEALTH_OK       = 2'd0,
    HEALTH_DEGRADED = 2'd1,
    HEALTH_CORRUPT  = 2'd2
  } health_t;

  // One input row
  typedef struct packed {
    logic [1:0]         channel;
    logic signed [63:0] ts_ns;
    logic signed [63:0] ingest_seq;
    logic signed [63:0] capture_seq;
    logic               last_row;
  } sic_row_t;

  // Per-run tracking plus the global failure counter and validation flag
  typedef struct packed {
    logic signed [63:0] prev_capture;
    logic signed [63:0] prev_ingest;
    logic               all_ingest;
    logic               all_capture;
    logic               any_ingest;
    logic               any_capture;
    logic signed [63:0] first_ts;
    logic               channel_failed;
    logic [31:0]        fail_total;
    logic               validation_seen;
  } sic_state_t;

  localparam sic_state_t STATE_RESET = '{
    prev_capture:    64'sd0,
    prev_ingest:     64'sd0,
    all_ingest:      1'b1,
    all_capture:     1'b1,
    any_ingest:      1'b0,
    any_capture:     1'b0,
    first_ts:        64'sd0,
    channel_failed:  1'b0,
    fail_total:      32'd0,
    validation_seen: 1'b0
  };

  // One result item
  typedef struct packed {
    logic [1:0]         channel_id;
    verdict_t           verdict;
    health_t            health;
    logic [31:0]        row_index;
    logic signed [63:0] incident_ts;
    logic signed [63:0] offending_seq;
    logic [31:0]        failure_count;
    logic               seq_checked;
    logic               channel_done;
  } sic_result_t;

endpackage

FILE: src/sic_if.sv
// Valid/ready channel interfaces for rows in and verdicts out.
interface sic_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         channel;
  logic signed [63:0] ts_ns;
  logic signed [63:0] ingest_seq;
  logic signed [63:0] capture_seq;
  logic               last_row;

  modport source (output valid, channel, ts_ns, ingest_seq, capture_seq, last_row,
                  input ready);
  modport sink   (input valid, channel, ts_ns, ingest_seq, capture_seq, last_row,
                  output ready);
endinterface

interface sic_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         channel_id;
  logic [2:0]         verdict;
  logic [1:0]         health;
  logic [31:0]        row_index;
  logic signed [63:0] incident_ts;
  logic signed [63:0] offending_seq;
  logic [31:0]        failure_count;
  logic               seq_checked;
  logic               channel_done;

  modport source (output valid, channel_id, verdict, health, row_index, incident_ts,
                  offending_seq, failure_count, seq_checked, channel_done,
                  input ready);
  modport sink   (input valid, channel_id, verdict, health, row_index, incident_ts,
                  offending_seq, failure_count, seq_checked, channel_done,
                  output ready);
endinterface

FILE: src/sic_row_eval.sv
// Combinational row check: next tracking state and the optional verdict for one row.
module sic_row_eval import sic_pkg::*; #(
  parameter int unsigned ROW_INDEX_BITS = ROW_INDEX_BITS_DEF
) (
  input  sic_row_t                  row_i,
  input  sic_state_t                st_i,
  input  logic [ROW_INDEX_BITS-1:0] pos_i,
  output sic_state_t                st_nxt_o,
  output logic [ROW_INDEX_BITS-1:0] pos_nxt_o,
  output logic                      res_valid_o,
  output sic_result_t               res_o
);

  logic        has_ing, has_cap;
  logic        cap_fail, ing_fail, row_fail;
  logic        cap_partial, ing_partial, end_corrupt, bump;
  sic_state_t  upd;
  logic [31:0] total_nxt;

  assign has_ing = row_i.ingest_seq  > 64'sd0;
  assign has_cap = row_i.capture_seq > 64'sd0;

  // Row failures: capture against last present capture, ingest against previous row
  assign cap_fail = has_cap && (st_i.prev_capture != 64'sd0)
                    && (row_i.capture_seq <= st_i.prev_capture);
  assign ing_fail = !cap_fail && has_ing && (st_i.prev_ingest > 64'sd0)
                    && (row_i.ingest_seq <= st_i.prev_ingest);
  assign row_fail = cap_fail || ing_fail;

  // Running presence flags including this row
  always_comb begin
    upd                 = st_i;
    upd.first_ts        = (pos_i == '0) ? row_i.ts_ns : st_i.first_ts;
    upd.all_ingest      = st_i.all_ingest  && has_ing;
    upd.all_capture     = st_i.all_capture && has_cap;
    upd.any_ingest      = st_i.any_ingest  || has_ing;
    upd.any_capture     = st_i.any_capture || has_cap;
    upd.validation_seen = st_i.validation_seen || has_cap;
    upd.prev_capture    = (has_cap && !cap_fail) ? row_i.capture_seq : st_i.prev_capture;
    upd.prev_ingest     = row_i.ingest_seq;
    upd.channel_failed  = row_fail;
  end

  // End-of-run checks only when the row itself passed
  assign cap_partial = upd.any_capture && !upd.all_capture;
  assign ing_partial = upd.any_ingest  && !upd.all_ingest;
  assign end_corrupt = !row_fail && row_i.last_row && (cap_partial || ing_partial);
  assign bump        = row_fail || end_corrupt;
  assign total_nxt   = (bump && (st_i.fail_total != '1)) ? st_i.fail_total + 32'd1
                                                         : st_i.fail_total;

  // Next state: failed runs hold until their last row, last row clears the run
  always_comb begin
    if (st_i.channel_failed) begin
      st_nxt_o  = st_i;
      pos_nxt_o = pos_i;
    end else begin
      st_nxt_o            = upd;
      st_nxt_o.fail_total = total_nxt;
      pos_nxt_o           = (pos_i == '1) ? pos_i : pos_i + 1'b1;
    end
    if (row_i.last_row) begin
      st_nxt_o                 = STATE_RESET;
      st_nxt_o.fail_total      = st_i.channel_failed ? st_i.fail_total : total_nxt;
      st_nxt_o.validation_seen = st_i.channel_failed ? st_i.validation_seen
                                                     : upd.validation_seen;
      pos_nxt_o                = '0;
    end
  end

  // Verdict selection
  always_comb begin
    res_valid_o         = !st_i.channel_failed && (row_fail || row_i.last_row);
    res_o.channel_id    = row_i.channel;
    res_o.failure_count = total_nxt;
    res_o.seq_checked   = upd.validation_seen;
    res_o.channel_done  = row_i.last_row;
    res_o.row_index     = 32'd0;
    res_o.incident_ts   = upd.first_ts;
    res_o.offending_seq = 64'sd0;
    if (cap_fail) begin
      res_o.verdict       = VERDICT_CAP_NONINC;
      res_o.health        = HEALTH_CORRUPT;
      res_o.row_index     = 32'(pos_i);
      res_o.incident_ts   = row_i.ts_ns;
      res_o.offending_seq = row_i.capture_seq;
    end else if (ing_fail) begin
      res_o.verdict       = VERDICT_ING_NONINC;
      res_o.health        = HEALTH_CORRUPT;
      res_o.row_index     = 32'(pos_i);
      res_o.incident_ts   = row_i.ts_ns;
      res_o.offending_seq = row_i.ingest_seq;
    end else if (cap_partial) begin
      res_o.verdict = VERDICT_CAP_PARTIAL;
      res_o.health  = HEALTH_CORRUPT;
    end else if (ing_partial) begin
      res_o.verdict = VERDICT_ING_PARTIAL;
      res_o.health  = HEALTH_CORRUPT;
    end else if (upd.any_capture != upd.any_ingest) begin
      res_o.verdict = upd.any_capture ? VERDICT_ING_ABSENT : VERDICT_CAP_ABSENT;
      res_o.health  = HEALTH_DEGRADED;
    end else begin
      res_o.verdict = VERDICT_OK;
      res_o.health  = HEALTH_OK;
    end
  end

endmodule

FILE: src/sequence_integrity_checker_top.sv
// Top level of the sequence integrity checker: row register, run state, verdict register.
// Takes one row per clock and gives at most one verdict per row, in row order. A row sits
// in an input register while its sequences are compared against the stored run state (a
// few 64-bit signed compares); the verdict lands in an output register and is offered from
// there, so the verdict is registered between the row transfer and the verdict transfer.
// Throughput is one row per cycle for as long as the verdict side keeps up; rows that
// produce no verdict pass even while a verdict waits. Row positions count up to the
// ROW_INDEX_BITS maximum and then hold; row_index reports the low 32 bits.
module sequence_integrity_checker_top import sic_pkg::*; #(
  parameter int unsigned ROW_INDEX_BITS = ROW_INDEX_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  sic_in_if.sink    in_ch,
  sic_out_if.source out_ch
);

  sic_row_t                  in_r;
  logic                      in_valid_r;
  sic_state_t                st_r, st_nxt;
  logic [ROW_INDEX_BITS-1:0] pos_r, pos_nxt;
  logic                      res_valid;
  sic_result_t               res, out_r;
  logic                      out_valid_r;
  logic                      advance, in_ready;

  // Row leaves the input register when its verdict (if any) has room
  assign advance  = in_valid_r && (!res_valid || !out_valid_r || out_ch.ready);
  assign in_ready = !in_valid_r || advance;
  assign in_ch.ready = in_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_ch.valid;
    end
    if (in_ready && in_ch.valid) begin
      in_r <= '{channel:     in_ch.channel,
                ts_ns:       in_ch.ts_ns,
                ingest_seq:  in_ch.ingest_seq,
                capture_seq: in_ch.capture_seq,
                last_row:    in_ch.last_row};
    end
  end

  sic_row_eval #(.ROW_INDEX_BITS(ROW_INDEX_BITS)) u_eval (
    .row_i       (in_r),
    .st_i        (st_r),
    .pos_i       (pos_r),
    .st_nxt_o    (st_nxt),
    .pos_nxt_o   (pos_nxt),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= STATE_RESET;
      pos_r <= '0;
    end else if (advance) begin
      st_r  <= st_nxt;
      pos_r <= pos_nxt;
    end
  end

  // Verdict register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (advance && res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.channel_id    = out_r.channel_id;
  assign out_ch.verdict       = out_r.verdict;
  assign out_ch.health        = out_r.health;
  assign out_ch.row_index     = out_r.row_index;
  assign out_ch.incident_ts   = out_r.incident_ts;
  assign out_ch.offending_seq = out_r.offending_seq;
  assign out_ch.failure_count = out_r.failure_count;
  assign out_ch.seq_checked   = out_r.seq_checked;
  assign out_ch.channel_done  = out_r.channel_done;

  // Failure total never goes backwards
  a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> st_r.fail_total >= $past(st_r.fail_total))
    else $error("failure total decreased");

  // A corrupt verdict bumps the total unless it is saturated
  a_corrupt_bumps: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_valid && res.health == HEALTH_CORRUPT |=>
      (st_r.fail_total == $past(st_r.fail_total) + 32'd1) || (st_r.fail_total == '1))
    else $error("corrupt verdict without failure count update");

  // Rows of a failed run never produce a verdict
  a_failed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && st_r.channel_failed |-> !res_valid)
    else $error("verdict from a failed run");

  // A closed run restarts at row zero with no failure flag
  a_run_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_r.last_row |=> pos_r == '0 && !st_r.channel_failed)
    else $error("run state not cleared after last row");

  // A pending verdict is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !(advance && res_valid))
    else $error("pending verdict overwritten");

endmodule
